FILE: rtl/core/pks_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pks_pkg: shared types for the popcount key sorter
// Sort word carried along the cell chain and control bundle for the cells.
// ----------------------------------------------------------------------------
package pks_pkg;

  localparam int VALUE_W = 64;
  localparam int COUNT_W = 7;

  // one entry of the sorting chain: value with its precomputed one-bit count
  typedef struct packed {
    logic                       valid;
    logic signed [VALUE_W-1:0]  value;
    logic [COUNT_W-1:0]         count;
  } sort_word_t;

  // control from the sequencer to every cell
  typedef struct packed {
    logic drain;   // chain is unloading toward cell 0
    logic shift;   // head word taken this cycle, move everything up one place
  } pks_ctl_t;

endpackage

FILE: rtl/core/pks_popcount.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pks_popcount: 64-bit population count
// Balanced adder tree over the bits of one value.
// ----------------------------------------------------------------------------
module pks_popcount (
  input  logic [pks_pkg::VALUE_W-1:0] value,
  output logic [pks_pkg::COUNT_W-1:0] count
);
  import pks_pkg::*;

  localparam int LEVELS = $clog2(VALUE_W);

  logic [COUNT_W-1:0] lvl [0:LEVELS][0:VALUE_W-1];

  // sum adjacent pairs, one tree level at a time
  always_comb begin
    for (int k = 0; k < VALUE_W; k++) begin
      lvl[0][k] = COUNT_W'(value[k]);
    end
    for (int l = 1; l <= LEVELS; l++) begin
      for (int k = 0; k < VALUE_W; k++) begin
        if (k < (VALUE_W >> l)) begin
          lvl[l][k] = lvl[l-1][2*k] + lvl[l-1][2*k+1];
        end else begin
          lvl[l][k] = '0;
        end
      end
    end
  end

  assign count = lvl[LEVELS][0];

endmodule

FILE: rtl/core/pks_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pks_cell: one insertion cell of the systolic sorter
// Keeps the better of its held word and the arriving word, passes the other
// to the right neighbor; during unload takes the right neighbor's word.
// ----------------------------------------------------------------------------
module pks_cell (
  input  logic                clk,
  input  logic                rst,
  input  pks_pkg::pks_ctl_t   ctl,
  input  pks_pkg::sort_word_t arrive,
  input  pks_pkg::sort_word_t right_held,
  output pks_pkg::sort_word_t held,
  output pks_pkg::sort_word_t pass
);
  import pks_pkg::*;

  // true when a must be emitted ahead of b: more one bits first, then lower value
  function automatic logic goes_before(input sort_word_t a, input sort_word_t b);
    logic result;
    if (a.count != b.count) begin
      result = a.count > b.count;
    end else begin
      result = a.value < b.value;
    end
    return result;
  endfunction

  logic take_arrive;

  assign take_arrive = arrive.valid && (!held.valid || goes_before(arrive, held));

  // insert while loading, shift up while unloading
  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
      pass.valid <= 1'b0;
    end else if (ctl.drain) begin
      pass.valid <= 1'b0;
      if (ctl.shift) begin
        held <= right_held;
      end
    end else if (take_arrive) begin
      held <= arrive;
      pass <= held;
    end else begin
      pass <= arrive;
    end
  end

endmodule

FILE: rtl/core/popcount_key_sorter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// popcount_key_sorter_top: batch sorter keyed on population count
// Sorts a batch of signed 64-bit values by one-bit count (descending), then
// by value (ascending), using a chain of CAPACITY insertion cells.
//
//   channel | handshake         | word
//   --------+-------------------+--------------------------------------------
//   input   | in_valid/in_stall | value, last_in
//   output  | out_valid/out_stall | sorted_value, ones_count, last_out, dropped
//
// Loading takes one word per cycle; each word ripples down the chain one cell
// per cycle while later words follow behind it.
// After the last word the chain settles in the flush state, then results leave
// from cell 0 at one per cycle while out_stall is low.
// Input is stalled from the accepted last word until the final result is taken.
// Reset (rst, synchronous) empties the chain and clears the fill count.
// Words beyond CAPACITY are dropped and flag every result of that batch.
// ----------------------------------------------------------------------------
module popcount_key_sorter_top #(
  parameter int CAPACITY = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [pks_pkg::VALUE_W-1:0] value,
  input  logic                               last_in,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [pks_pkg::VALUE_W-1:0] sorted_value,
  output logic [pks_pkg::COUNT_W-1:0]        ones_count,
  output logic                               last_out,
  output logic                               dropped
);
  import pks_pkg::*;

  localparam int FILL_W  = $clog2(CAPACITY + 1);
  localparam int FLUSH_W = $clog2(CAPACITY);

  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_FLUSH = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t             state;
  logic [FILL_W-1:0]  fill;
  logic [FLUSH_W-1:0] flush_cnt;
  logic               overflow;

  logic               in_take;
  logic               out_take;
  logic               has_room;
  logic [COUNT_W-1:0] in_count;
  pks_ctl_t           ctl;

  sort_word_t arrive_word [0:CAPACITY];
  sort_word_t held_word   [0:CAPACITY];

  assign in_stall  = (state != ST_LOAD);
  assign in_take   = in_valid && !in_stall;
  assign out_valid = (state == ST_DRAIN);
  assign out_take  = out_valid && !out_stall;
  assign has_room  = (fill < FILL_W'(CAPACITY));

  assign ctl.drain = (state == ST_DRAIN);
  assign ctl.shift = out_take;

  // count ones of the arriving word
  pks_popcount u_popcount (
    .value (value),
    .count (in_count)
  );

  // feed cell 0; dropped words never enter the chain
  assign arrive_word[0].valid = in_take && has_room;
  assign arrive_word[0].value = value;
  assign arrive_word[0].count = in_count;
  assign held_word[CAPACITY]  = '0;

  // build the cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    pks_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .arrive     (arrive_word[i]),
      .right_held (held_word[i+1]),
      .held       (held_word[i]),
      .pass       (arrive_word[i+1])
    );
  end

  // sequence load, settle and unload
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      fill      <= '0;
      flush_cnt <= '0;
      overflow  <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (in_take) begin
            if (has_room) begin
              fill <= fill + FILL_W'(1);
            end else begin
              overflow <= 1'b1;
            end
            if (last_in) begin
              state     <= ST_FLUSH;
              flush_cnt <= '0;
            end
          end
        end
        ST_FLUSH: begin
          flush_cnt <= flush_cnt + FLUSH_W'(1);
          if (flush_cnt == FLUSH_W'(CAPACITY - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (out_take) begin
            fill <= fill - FILL_W'(1);
            if (fill == FILL_W'(1)) begin
              state    <= ST_LOAD;
              overflow <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // head of the chain is the next result
  assign sorted_value = held_word[0].value;
  assign ones_count   = held_word[0].count;
  assign last_out     = (fill == FILL_W'(1));
  assign dropped      = overflow;

endmodule

FILE: test/pks_sort_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pks_sort_check_pkg: scoreboard for the popcount key sorter
// Collects each batch of accepted words, orders it by one-bit count
// (descending) then signed value (ascending), and checks result words in order.
// ----------------------------------------------------------------------------
package pks_sort_check_pkg;

  import pks_pkg::*;

  // one expected result word
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [COUNT_W-1:0]        count;
    logic                      last;
    logic                      dropped;
  } sorted_word_t;

  class sorted_batch_board;
    int                        capacity;
    logic signed [VALUE_W-1:0] held[$];
    bit                        overflow;
    sorted_word_t              expected_words[$];
    int                        errors;
    int                        words_in;
    int                        results_out;
    int                        batches;
    int                        overflow_batches;

    function new(int cap);
      capacity         = cap;
      overflow         = 1'b0;
      errors           = 0;
      words_in         = 0;
      results_out      = 0;
      batches          = 0;
      overflow_batches = 0;
    endfunction

    // true when a leaves ahead of b
    function bit leads(logic signed [VALUE_W-1:0] a, logic signed [VALUE_W-1:0] b);
      int ca;
      int cb;
      ca = $countones(a);
      cb = $countones(b);
      if (ca != cb) return ca > cb;
      return a < b;
    endfunction

    // store an accepted word; on the batch end, queue the sorted batch
    function void note_word(logic signed [VALUE_W-1:0] v, logic lst);
      logic signed [VALUE_W-1:0] order[$];
      sorted_word_t              w;
      int                        j;
      words_in++;
      if (held.size() < capacity) held.push_back(v);
      else overflow = 1'b1;
      if (!lst) return;
      // insertion sort of the held batch
      foreach (held[i]) begin
        j = order.size();
        while (j > 0 && leads(held[i], order[j-1])) j--;
        order.insert(j, held[i]);
      end
      foreach (order[i]) begin
        w.value   = order[i];
        w.count   = COUNT_W'($countones(order[i]));
        w.last    = (i == order.size() - 1);
        w.dropped = overflow;
        expected_words.push_back(w);
      end
      batches++;
      if (overflow) overflow_batches++;
      held.delete();
      overflow = 1'b0;
    endfunction

    // compare one accepted result word with the oldest expectation
    function void check_result(logic signed [VALUE_W-1:0] v, logic [COUNT_W-1:0] cnt,
                               logic lst, logic drp);
      sorted_word_t w;
      results_out++;
      if (expected_words.size() == 0) begin
        errors++;
        $error("unexpected result word: sorted_value %0d", v);
        return;
      end
      w = expected_words.pop_front();
      if (v !== w.value) begin
        errors++;
        $error("sorted_value: expected %0d, got %0d", w.value, v);
      end
      if (cnt !== w.count) begin
        errors++;
        $error("ones_count: expected %0d, got %0d", w.count, cnt);
      end
      if (lst !== w.last) begin
        errors++;
        $error("last_out: expected %0b, got %0b", w.last, lst);
      end
      if (drp !== w.dropped) begin
        errors++;
        $error("dropped: expected %0b, got %0b", w.dropped, drp);
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // count any result words that never showed up
    function void flag_leftovers();
      if (expected_words.size() != 0) begin
        errors++;
        $error("%0d expected result words never arrived", expected_words.size());
      end
    endfunction
  endclass

endpackage

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for popcount_key_sorter_top
// Drives batches of signed 64-bit words (extremes, ties, full and overflowing
// batches, random content) under several input/output stall mixes and checks
// every sorted result word against a scoreboard.
// ----------------------------------------------------------------------------
module tb_top;

  import pks_pkg::*;
  import pks_sort_check_pkg::*;

  localparam int CAPACITY    = 64;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_WORDS = 15;
  localparam logic signed [VALUE_W-1:0] MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] MOST_POS = {1'b0, {(VALUE_W-1){1'b1}}};

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  logic signed [VALUE_W-1:0] value     = '0;
  logic                      last_in   = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [VALUE_W-1:0] sorted_value;
  logic [COUNT_W-1:0]        ones_count;
  logic                      last_out;
  logic                      dropped;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  sorted_batch_board board;

  popcount_key_sorter_top #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .last_in      (last_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sorted_value (sorted_value),
    .ones_count   (ones_count),
    .last_out     (last_out),
    .dropped      (dropped)
  );

  always #1 clk = ~clk;

  // stall the output side at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // watch both channels, feed the scoreboard, and time out on a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) board.note_word(value, last_in);
      if (out_valid && !out_stall)
        board.check_result(sorted_value, ones_count, last_out, dropped);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // present one word, idling first at random, and hold it until taken
  task automatic send_word(input logic signed [VALUE_W-1:0] v, input logic lst);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    last_in  <= lst;
    do @(posedge clk); while (in_stall);
  endtask

  // hold off the input until every expected result word has left
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // pick a word: plain random, sparse, dense, small, extreme, or a tie with prev
  function automatic logic signed [VALUE_W-1:0] pick_value(
      logic signed [VALUE_W-1:0] prev, bit have_prev);
    int         kind;
    int         small_val;
    int         sh;
    logic [VALUE_W-1:0] u;
    kind = $urandom_range(0, 9);
    if (!have_prev && kind >= 8) kind = 0;
    case (kind)
      4: return (64'd1 << $urandom_range(0, 63)) | (64'd1 << $urandom_range(0, 63));
      5: return ~(64'd1 << $urandom_range(0, 63));
      6: begin
        small_val = $urandom_range(0, 16);
        return VALUE_W'(small_val - 8);
      end
      7: begin
        case ($urandom_range(0, 4))
          0: return '0;
          1: return '1;
          2: return MOST_NEG;
          3: return MOST_POS;
          default: return VALUE_W'(1);
        endcase
      end
      8: return prev;
      9: begin
        // rotate keeps the one-bit count, so it forces a count tie that value decides
        sh = $urandom_range(1, VALUE_W - 1);
        u  = prev;
        return (u << sh) | (u >> (VALUE_W - sh));
      end
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // send one batch of random content, marking the final word
  task automatic send_random_batch(input int len);
    logic signed [VALUE_W-1:0] prev;
    logic signed [VALUE_W-1:0] v;
    prev = '0;
    for (int k = 0; k < len; k++) begin
      v = pick_value(prev, k > 0);
      send_word(v, k == len - 1);
      prev = v;
    end
  endtask

  initial begin
    int phase_words;
    int len;
    int r;
    board = new(CAPACITY);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // single-word batch
    send_word(64'sd0, 1'b1);
    // extremes of the one-bit count, with a count-one tie across the sign
    send_word(-64'sd1, 1'b0);
    send_word(MOST_NEG, 1'b0);
    send_word(MOST_POS, 1'b0);
    send_word(64'sd0, 1'b0);
    send_word(64'sd1, 1'b1);
    // count-two ties with a duplicate
    send_word(64'sd6, 1'b0);
    send_word(64'sd3, 1'b0);
    send_word(64'sd5, 1'b0);
    send_word(64'sd3, 1'b0);
    send_word(64'h0000_0000_0000_00C0, 1'b1);
    // count-63 ties across the sign
    send_word(-64'sd2, 1'b0);
    send_word(MOST_POS, 1'b0);
    send_word(64'hBFFF_FFFF_FFFF_FFFF, 1'b1);
    // alternating patterns, equal count
    send_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_word(64'h5555_5555_5555_5555, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      // in phase 2, fill the store, drop words before the last one, and let the last
      // word land in a full store
      case (phase)
        2: send_random_batch(CAPACITY + 3);
        default: ;
      endcase
      phase_words = 0;
      while (phase_words < PHASE_WORDS) begin
        r = $urandom_range(0, 99);
        if (r < 90) len = $urandom_range(1, 8);
        else len = $urandom_range(9, 20);
        send_random_batch(len);
        phase_words += len;
      end
    end

    wait_drained();
    repeat (2 * CAPACITY + 16) @(posedge clk);
    board.flag_leftovers();
    $display("Sorted %0d batches from %0d words (%0d batches overflowed), %0d results checked.",
             board.batches, board.words_in, board.overflow_batches, board.results_out);
    $display("Handshake mixes: free flow, sparse input, heavy output stall, light both.");
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/pks_pkg.sv
rtl/core/pks_popcount.sv
rtl/core/pks_cell.sv
rtl/core/popcount_key_sorter_top.sv
test/pks_sort_check_pkg.sv
test/tb_top.sv
